FILE: hdl/vmfp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vmfp_pkg
// Shared constants and helpers for the view matrix from pose pipeline.
// ----------------------------------------------------------------------------
package vmfp_pkg;

  localparam int ANGLE_FRAC_BITS = 13;
  localparam int UNIT_FRAC_BITS  = 14;
  localparam int POS_WIDTH       = 32;
  localparam int CORDIC_STEPS    = 16;
  localparam int IQ              = 30;

  localparam int ANG_W  = 16;
  localparam int UNIT_W = 16;
  localparam int TRANS_W = 34;
  localparam int ZW     = 36;
  localparam int XW     = 34;
  localparam int PROD_W = POS_WIDTH + UNIT_W;
  localparam int SUM_W  = PROD_W + 2;

  localparam logic signed [ZW-1:0] Q30_PI      = 36'sd3373259426;
  localparam logic signed [ZW-1:0] Q30_HALF_PI = 36'sd1686629713;
  localparam logic signed [ZW-1:0] Q30_TWO_PI  = 36'sd6746518852;
  localparam logic signed [XW-1:0] Q30_GAIN    = 34'sd652032874;

  localparam logic signed [TRANS_W:0] TRANS_MAX = 35'sd8589934591;
  localparam logic signed [TRANS_W:0] TRANS_MIN = -35'sd8589934592;

  function automatic logic signed [ZW-1:0] atan_q30(input int i);
    logic signed [ZW-1:0] a;
    case (i)
      0: a = 36'sd843314857;
      1: a = 36'sd497837829;
      2: a = 36'sd263043837;
      3: a = 36'sd133525159;
      4: a = 36'sd67021687;
      5: a = 36'sd33543516;
      6: a = 36'sd16775851;
      7: a = 36'sd8388437;
      8: a = 36'sd4194283;
      9: a = 36'sd2097149;
      default: begin
        if (i <= 30) a = ZW'(64'sd1 <<< (30 - i));
        else a = '0;
      end
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/view_matrix_from_pose_top.sv
`default_nettype none
// start runs down vld[0..N], then u_vld, m_vld, t_vld and on to done.
// Throughput: one request per cycle; busy is always low, one CORDIC
// iteration per pipeline stage for pitch and yaw side by side.
// Reset clears the valid bits of every stage; payload is not reset.
// The receiver cannot stall: each result shows for one cycle with done.
// ----------------------------------------------------------------------------
// view_matrix_from_pose_top
// Camera axes and translations from pitch, yaw and position, pipelined.
// ----------------------------------------------------------------------------
module view_matrix_from_pose_top
  import vmfp_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic signed [ANG_W-1:0]     pitch_angle,
  input  wire logic signed [ANG_W-1:0]     yaw_angle,
  input  wire logic signed [POS_WIDTH-1:0] pos_x,
  input  wire logic signed [POS_WIDTH-1:0] pos_y,
  input  wire logic signed [POS_WIDTH-1:0] pos_z,
  output logic                             done,
  output logic signed [UNIT_W-1:0]         right_x,
  output logic signed [UNIT_W-1:0]         right_z,
  output logic signed [UNIT_W-1:0]         up_x,
  output logic signed [UNIT_W-1:0]         up_y,
  output logic signed [UNIT_W-1:0]         up_z,
  output logic signed [UNIT_W-1:0]         fwd_x,
  output logic signed [UNIT_W-1:0]         fwd_y,
  output logic signed [UNIT_W-1:0]         fwd_z,
  output logic signed [TRANS_W-1:0]        trans_right,
  output logic signed [TRANS_W-1:0]        trans_up,
  output logic signed [TRANS_W-1:0]        trans_fwd,
  output logic                             degenerate
);

  localparam int N = CORDIC_STEPS;
  localparam int SH = IQ - UNIT_FRAC_BITS;

  function automatic logic [ZW:0] reduce(input logic signed [ANG_W-1:0] raw);
    logic signed [ZW-1:0] z;
    logic neg;
    z = ZW'(raw) <<< (IQ - ANGLE_FRAC_BITS);
    neg = 1'b0;
    if (z > Q30_PI) z = z - Q30_TWO_PI;
    if (z < -Q30_PI) z = z + Q30_TWO_PI;
    if (z > Q30_HALF_PI) begin
      z = z - Q30_PI;
      neg = 1'b1;
    end else if (z < -Q30_HALF_PI) begin
      z = z + Q30_PI;
      neg = 1'b1;
    end
    return {neg, z};
  endfunction

  function automatic logic signed [UNIT_W-1:0] to_unit(input logic signed [XW-1:0] x,
                                                       input logic neg);
    logic signed [XW+1:0] v;
    logic signed [XW+1:0] r;
    v = neg ? -(XW+2)'(x) : (XW+2)'(x);
    r = (v + ((XW+2)'(1) <<< (SH - 1))) >>> SH;
    if (r > (XW+2)'(1 <<< UNIT_FRAC_BITS)) r = (XW+2)'(1 <<< UNIT_FRAC_BITS);
    if (r < -(XW+2)'(1 <<< UNIT_FRAC_BITS)) r = -(XW+2)'(1 <<< UNIT_FRAC_BITS);
    return UNIT_W'(r);
  endfunction

  function automatic logic signed [UNIT_W-1:0] mul_round(input logic signed [UNIT_W-1:0] a,
                                                         input logic signed [UNIT_W-1:0] b);
    logic signed [2*UNIT_W-1:0] p;
    p = (2*UNIT_W)'(a) * (2*UNIT_W)'(b) + (2*UNIT_W)'(1 <<< (UNIT_FRAC_BITS - 1));
    return UNIT_W'(p >>> UNIT_FRAC_BITS);
  endfunction

  function automatic logic signed [TRANS_W-1:0] finish(input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W-1:0] r;
    logic signed [SUM_W-1:0] n;
    r = (s + SUM_W'(1 <<< (UNIT_FRAC_BITS - 1))) >>> UNIT_FRAC_BITS;
    n = -r;
    if (n > SUM_W'(TRANS_MAX)) n = SUM_W'(TRANS_MAX);
    if (n < SUM_W'(TRANS_MIN)) n = SUM_W'(TRANS_MIN);
    return TRANS_W'(n);
  endfunction

  // CORDIC stages
  logic                  vld [0:N];
  logic signed [XW-1:0]  px [0:N];
  logic signed [XW-1:0]  py [0:N];
  logic signed [ZW-1:0]  pz [0:N];
  logic                  pn [0:N];
  logic signed [XW-1:0]  yx [0:N];
  logic signed [XW-1:0]  yy [0:N];
  logic signed [ZW-1:0]  yz [0:N];
  logic                  yn [0:N];
  logic signed [POS_WIDTH-1:0] qx [0:N];
  logic signed [POS_WIDTH-1:0] qy [0:N];
  logic signed [POS_WIDTH-1:0] qz [0:N];

  logic signed [XW-1:0]  px_next [0:N-1];
  logic signed [XW-1:0]  py_next [0:N-1];
  logic signed [ZW-1:0]  pz_next [0:N-1];
  logic signed [XW-1:0]  yx_next [0:N-1];
  logic signed [XW-1:0]  yy_next [0:N-1];
  logic signed [ZW-1:0]  yz_next [0:N-1];

  logic [ZW:0] pred;
  logic [ZW:0] yred;

  assign busy = 1'b0;
  assign pred = reduce(pitch_angle);
  assign yred = reduce(yaw_angle);

  always_comb begin
    for (int i = 0; i < N; i++) begin
      if (pz[i] >= 0) begin
        px_next[i] = px[i] - (py[i] >>> i);
        py_next[i] = py[i] + (px[i] >>> i);
        pz_next[i] = pz[i] - atan_q30(i);
      end else begin
        px_next[i] = px[i] + (py[i] >>> i);
        py_next[i] = py[i] - (px[i] >>> i);
        pz_next[i] = pz[i] + atan_q30(i);
      end
      if (yz[i] >= 0) begin
        yx_next[i] = yx[i] - (yy[i] >>> i);
        yy_next[i] = yy[i] + (yx[i] >>> i);
        yz_next[i] = yz[i] - atan_q30(i);
      end else begin
        yx_next[i] = yx[i] + (yy[i] >>> i);
        yy_next[i] = yy[i] - (yx[i] >>> i);
        yz_next[i] = yz[i] + atan_q30(i);
      end
    end
  end

  // unit, product, multiply and sum stages
  logic u_vld, m_vld, t_vld;
  logic signed [UNIT_W-1:0] cp, sp, cy, sy;
  logic signed [POS_WIDTH-1:0] ux, uy, uz, mx, my, mz;
  logic signed [UNIT_W-1:0] m_rx, m_rz, m_ux, m_uy, m_uz, m_fx, m_fy, m_fz;
  logic m_dg;
  logic signed [UNIT_W-1:0] t_rx, t_rz, t_ux, t_uy, t_uz, t_fx, t_fy, t_fz;
  logic t_dg;
  logic signed [PROD_W-1:0] pr0, pr2, pu0, pu1, pu2, pf0, pf1, pf2;
  logic signed [UNIT_W-1:0] up0, up2, f0, f2;
  logic sg, dg;

  assign f0  = -mul_round(cp, cy);
  assign f2  = -mul_round(cp, sy);
  assign up0 = mul_round(cy, sp);
  assign up2 = mul_round(sy, sp);
  assign dg  = (cp == '0);
  assign sg  = cp[UNIT_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= N; i++) vld[i] <= 1'b0;
      u_vld <= 1'b0;
      m_vld <= 1'b0;
      t_vld <= 1'b0;
      done  <= 1'b0;
    end else begin
      vld[0] <= start;
      for (int i = 0; i < N; i++) vld[i+1] <= vld[i];
      u_vld <= vld[N];
      m_vld <= u_vld;
      t_vld <= m_vld;
      done  <= t_vld;
    end
  end

  always_ff @(posedge clk) begin
    px[0] <= Q30_GAIN;
    py[0] <= '0;
    pz[0] <= ZW'(pred[ZW-1:0]);
    pn[0] <= pred[ZW];
    yx[0] <= Q30_GAIN;
    yy[0] <= '0;
    yz[0] <= ZW'(yred[ZW-1:0]);
    yn[0] <= yred[ZW];
    qx[0] <= pos_x;
    qy[0] <= pos_y;
    qz[0] <= pos_z;
    for (int i = 0; i < N; i++) begin
      px[i+1] <= px_next[i];
      py[i+1] <= py_next[i];
      pz[i+1] <= pz_next[i];
      pn[i+1] <= pn[i];
      yx[i+1] <= yx_next[i];
      yy[i+1] <= yy_next[i];
      yz[i+1] <= yz_next[i];
      yn[i+1] <= yn[i];
      qx[i+1] <= qx[i];
      qy[i+1] <= qy[i];
      qz[i+1] <= qz[i];
    end

    cp <= to_unit(px[N], pn[N]);
    sp <= to_unit(py[N], pn[N]);
    cy <= to_unit(yx[N], yn[N]);
    sy <= to_unit(yy[N], yn[N]);
    ux <= qx[N];
    uy <= qy[N];
    uz <= qz[N];

    m_fx <= f0;
    m_fy <= -sp;
    m_fz <= f2;
    m_dg <= dg;
    if (dg) begin
      m_rx <= '0;
      m_rz <= '0;
      m_ux <= '0;
      m_uy <= '0;
      m_uz <= '0;
    end else begin
      m_rx <= sg ? -sy : sy;
      m_rz <= sg ? cy : -cy;
      m_ux <= sg ? up0 : -up0;
      m_uy <= sg ? -cp : cp;
      m_uz <= sg ? up2 : -up2;
    end
    mx <= ux;
    my <= uy;
    mz <= uz;

    pr0 <= PROD_W'(mx) * PROD_W'(m_rx);
    pr2 <= PROD_W'(mz) * PROD_W'(m_rz);
    pu0 <= PROD_W'(mx) * PROD_W'(m_ux);
    pu1 <= PROD_W'(my) * PROD_W'(m_uy);
    pu2 <= PROD_W'(mz) * PROD_W'(m_uz);
    pf0 <= PROD_W'(mx) * PROD_W'(m_fx);
    pf1 <= PROD_W'(my) * PROD_W'(m_fy);
    pf2 <= PROD_W'(mz) * PROD_W'(m_fz);
    t_rx <= m_rx;
    t_rz <= m_rz;
    t_ux <= m_ux;
    t_uy <= m_uy;
    t_uz <= m_uz;
    t_fx <= m_fx;
    t_fy <= m_fy;
    t_fz <= m_fz;
    t_dg <= m_dg;

    right_x <= t_rx;
    right_z <= t_rz;
    up_x <= t_ux;
    up_y <= t_uy;
    up_z <= t_uz;
    fwd_x <= t_fx;
    fwd_y <= t_fy;
    fwd_z <= t_fz;
    degenerate <= t_dg;
    trans_right <= finish(SUM_W'(pr0) + SUM_W'(pr2));
    trans_up <= finish(SUM_W'(pu0) + SUM_W'(pu1) + SUM_W'(pu2));
    trans_fwd <= finish(SUM_W'(pf0) + SUM_W'(pf1) + SUM_W'(pf2));
  end

endmodule
`default_nettype wire

FILE: tb/sv/view_matrix_from_pose_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// view_matrix_from_pose_checker
// Watches requests and results of the pose pipeline, computes the expected
// camera axes and translations for each request and compares every result.
// ----------------------------------------------------------------------------
module view_matrix_from_pose_checker
  import vmfp_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic                        busy,
  input  wire logic signed [ANG_W-1:0]     pitch_angle,
  input  wire logic signed [ANG_W-1:0]     yaw_angle,
  input  wire logic signed [POS_WIDTH-1:0] pos_x,
  input  wire logic signed [POS_WIDTH-1:0] pos_y,
  input  wire logic signed [POS_WIDTH-1:0] pos_z,
  input  wire logic                        done,
  input  wire logic signed [UNIT_W-1:0]    right_x,
  input  wire logic signed [UNIT_W-1:0]    right_z,
  input  wire logic signed [UNIT_W-1:0]    up_x,
  input  wire logic signed [UNIT_W-1:0]    up_y,
  input  wire logic signed [UNIT_W-1:0]    up_z,
  input  wire logic signed [UNIT_W-1:0]    fwd_x,
  input  wire logic signed [UNIT_W-1:0]    fwd_y,
  input  wire logic signed [UNIT_W-1:0]    fwd_z,
  input  wire logic signed [TRANS_W-1:0]   trans_right,
  input  wire logic signed [TRANS_W-1:0]   trans_up,
  input  wire logic signed [TRANS_W-1:0]   trans_fwd,
  input  wire logic                        degenerate,
  output int                               errors,
  output int                               pending,
  output int                               degen_count
);

  typedef struct packed {
    logic signed [UNIT_W-1:0]  rx, rz, ux, uy, uz, fx, fy, fz;
    logic signed [TRANS_W-1:0] tr, tu, tf;
    logic                      dg;
  } view_t;

  localparam longint PI_Q30    = 64'sd3373259426;
  localparam longint HPI_Q30   = 64'sd1686629713;
  localparam longint TWOPI_Q30 = 64'sd6746518852;
  localparam longint GAIN_Q30  = 64'sd652032874;
  localparam longint T_MAX     = 64'sd8589934591;
  localparam longint T_MIN     = -64'sd8589934592;
  localparam longint ONE_U     = 64'sd1 <<< UNIT_FRAC_BITS;

  localparam longint ARCTAN [10] = '{843314857, 497837829, 263043837, 133525159,
    67021687, 33543516, 16775851, 8388437, 4194283, 2097149};

  view_t expected_views[$];

  function automatic longint quant_unit(longint v);
    longint r;
    r = (v + (64'sd1 <<< (IQ - UNIT_FRAC_BITS - 1))) >>> (IQ - UNIT_FRAC_BITS);
    if (r > ONE_U) r = ONE_U;
    if (r < -ONE_U) r = -ONE_U;
    return r;
  endfunction

  function automatic void rotate_angle(input logic signed [ANG_W-1:0] ang,
                                       output longint c, output longint s);
    longint z, x, y, dx, dy, a;
    logic flip;
    z = longint'(ang) * (64'sd1 <<< (IQ - ANGLE_FRAC_BITS));
    x = GAIN_Q30;
    y = 0;
    flip = 1'b0;
    z = z % TWOPI_Q30;
    if (z > PI_Q30) z -= TWOPI_Q30;
    if (z < -PI_Q30) z += TWOPI_Q30;
    if (z > HPI_Q30) begin
      z -= PI_Q30; flip = 1'b1;
    end else if (z < -HPI_Q30) begin
      z += PI_Q30; flip = 1'b1;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      a = (i < 10) ? ARCTAN[i] : ((i <= 30) ? (64'sd1 <<< (30 - i)) : 0);
      if (z >= 0) begin
        x -= dx; y += dy; z -= a;
      end else begin
        x += dx; y -= dy; z += a;
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = quant_unit(x);
    s = quant_unit(y);
  endfunction

  function automatic longint unit_product(longint a, longint b);
    return (a * b + (64'sd1 <<< (UNIT_FRAC_BITS - 1))) >>> UNIT_FRAC_BITS;
  endfunction

  function automatic longint neg_dot(longint p0, longint p1, longint p2,
                                     longint a0, longint a1, longint a2);
    longint hi, lo, h, l, bnd, res;
    hi = (p0 >>> 16) * a0 + (p1 >>> 16) * a1 + (p2 >>> 16) * a2;
    lo = (p0 & 64'hFFFF) * a0 + (p1 & 64'hFFFF) * a1 + (p2 & 64'hFFFF) * a2;
    h = hi + (lo >>> 16);
    l = lo & 64'hFFFF;
    bnd = 64'sd1 <<< (UNIT_FRAC_BITS + 18);
    if (h > bnd) h = bnd;
    if (h < -bnd) h = -bnd;
    res = h * (64'sd1 <<< (16 - UNIT_FRAC_BITS))
        + ((l + (64'sd1 <<< (UNIT_FRAC_BITS - 1))) >>> UNIT_FRAC_BITS);
    res = -res;
    if (res > T_MAX) res = T_MAX;
    if (res < T_MIN) res = T_MIN;
    return res;
  endfunction

  function automatic view_t predict_view(logic signed [ANG_W-1:0] p,
                                         logic signed [ANG_W-1:0] w,
                                         longint px, longint py, longint pz);
    view_t v;
    longint cp, sp, cy, sy, sg, fx, fy, fz, rx, rz, ux, uy, uz;
    rotate_angle(p, cp, sp);
    rotate_angle(w, cy, sy);
    fx = -unit_product(cp, cy);
    fy = -sp;
    fz = -unit_product(cp, sy);
    sg = (cp < 0) ? -1 : 1;
    if (cp == 0) begin
      rx = 0; rz = 0; ux = 0; uy = 0; uz = 0;
    end else begin
      rx = sg * sy;
      rz = -sg * cy;
      ux = -sg * unit_product(cy, sp);
      uy = sg * cp;
      uz = -sg * unit_product(sy, sp);
    end
    v.rx = UNIT_W'(rx); v.rz = UNIT_W'(rz);
    v.ux = UNIT_W'(ux); v.uy = UNIT_W'(uy); v.uz = UNIT_W'(uz);
    v.fx = UNIT_W'(fx); v.fy = UNIT_W'(fy); v.fz = UNIT_W'(fz);
    v.tr = TRANS_W'(neg_dot(px, py, pz, rx, 0, rz));
    v.tu = TRANS_W'(neg_dot(px, py, pz, ux, uy, uz));
    v.tf = TRANS_W'(neg_dot(px, py, pz, fx, fy, fz));
    v.dg = (cp == 0);
    return v;
  endfunction

  assign pending = expected_views.size();

  always @(posedge clk) begin
    view_t e, got;
    if (rst) begin
      errors <= 0;
      degen_count <= 0;
      expected_views.delete();
    end else begin
      if (start && !busy)
        expected_views.push_back(predict_view(pitch_angle, yaw_angle,
          longint'(pos_x), longint'(pos_y), longint'(pos_z)));
      if (done) begin
        got = '{right_x, right_z, up_x, up_y, up_z, fwd_x, fwd_y, fwd_z,
                trans_right, trans_up, trans_fwd, degenerate};
        if (expected_views.size() == 0) begin
          errors <= errors + 1;
          if (errors < 10) $display("result with no request pending: %p", got);
        end else begin
          e = expected_views.pop_front();
          if (e.dg) degen_count <= degen_count + 1;
          if (got !== e) begin
            errors <= errors + 1;
            if (errors < 10) $display("mismatch\n  expected %p\n  actual   %p", e, got);
          end
        end
      end
    end
  end

endmodule

FILE: tb/sv/view_matrix_from_pose_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// view_matrix_from_pose_top_tb
// Drives directed and random camera poses through the pose pipeline under
// several sender idle patterns; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module view_matrix_from_pose_top_tb
  import vmfp_pkg::*;
();

  localparam int WATCHDOG = 5000;
  localparam logic signed [ANG_W-1:0] ANG_MAX  = 16'sd25736;
  localparam logic signed [ANG_W-1:0] ANG_HALF = 16'sd12868;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done, degenerate;
  logic signed [ANG_W-1:0] pitch_angle = '0, yaw_angle = '0;
  logic signed [POS_WIDTH-1:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic signed [UNIT_W-1:0] right_x, right_z, up_x, up_y, up_z, fwd_x, fwd_y, fwd_z;
  logic signed [TRANS_W-1:0] trans_right, trans_up, trans_fwd;
  int errors, pending, degen_count, sent, quiet, idle_pct;

  always #1 clk = ~clk;

  view_matrix_from_pose_top u_top (.*);
  view_matrix_from_pose_checker u_chk (.*);

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCHDOG) begin
      $display("[view_matrix_from_pose_top] ERROR");
      $finish;
    end
  end

  function automatic logic signed [ANG_W-1:0] rand_angle();
    case ($urandom_range(0, 5))
      0: return ANG_W'($urandom_range(0, 6) - 3 +
                       ($urandom_range(0, 1) ? ANG_HALF : -ANG_HALF));
      1: return ANG_W'($urandom_range(0, 1) ? ANG_MAX - $urandom_range(0, 3)
                                            : -ANG_MAX + $urandom_range(0, 3));
      default: return ANG_W'($urandom_range(0, 2 * 25736) - 25736);
    endcase
  endfunction

  function automatic logic signed [POS_WIDTH-1:0] rand_pos();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
      1: return $signed($urandom_range(0, 2000000)) - 1000000;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_pose(logic signed [ANG_W-1:0] p, logic signed [ANG_W-1:0] w,
                           logic signed [POS_WIDTH-1:0] x,
                           logic signed [POS_WIDTH-1:0] y,
                           logic signed [POS_WIDTH-1:0] z);
    start <= 1'b1;
    pitch_angle <= p; yaw_angle <= w;
    pos_x <= x; pos_y <= y; pos_z <= z;
    do @(posedge clk); while (busy);
    sent++;
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  initial begin
    logic signed [ANG_W-1:0] angs [10];
    sent = 0;
    idle_pct = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    angs = '{16'sd0, ANG_MAX, -ANG_MAX, ANG_HALF, -ANG_HALF, 16'sd12867,
             -16'sd12867, 16'sd12869, 16'sd6434, -16'sd1};
    for (int i = 0; i < 10; i++)
      send_pose(angs[i], angs[9 - i], 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF);
    for (int i = 0; i < 10; i++)
      send_pose(angs[(i * 3) % 10], angs[i], 32'sh80000000, 32'sh80000000,
                32'sh80000000);
    send_pose(16'sd0, 16'sd0, '0, '0, '0);
    send_pose(16'sd0, 16'sd0, 32'sh00010000, -32'sh00010000, 32'sh00008000);

    // hold until drained
    start <= 1'b0;
    wait (pending == 0);
    @(posedge clk);

    for (int phase = 0; phase < 4; phase++) begin
      idle_pct = (phase == 1) ? 48 : (phase == 3) ? 35 : 0;
      for (int n = 0; n < 200; n++)
        send_pose(rand_angle(), rand_angle(), rand_pos(), rand_pos(), rand_pos());
    end
    start <= 1'b0;

    wait (pending == 0);
    repeat (30) @(posedge clk);
    $display("poses sent: %0d, degenerate pitch results: %0d, mismatches: %0d",
             sent, degen_count, errors);
    $display("covered angle extremes, half-turn pitch, full-scale positions, idle mixes");
    if (errors == 0)
      $display("[view_matrix_from_pose_top] OK");
    else
      $display("[view_matrix_from_pose_top] ERROR");
    $finish;
  end

endmodule
